@@ src/rational_arith_unit_macros.svh @@
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ src/rau_pkg.sv @@
// Types and codes shared by the rational arithmetic unit.
package rau_pkg;
	localparam logic [2:0] MODE_NORM = 3'd0;
	localparam logic [2:0] MODE_ADD  = 3'd1;
	localparam logic [2:0] MODE_SUB  = 3'd2;
	localparam logic [2:0] MODE_MUL  = 3'd3;
	localparam logic [2:0] MODE_DIV  = 3'd4;
	localparam logic [2:0] MODE_EQ   = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic               equal;
		logic [1:0]         status;
	} out_item_t;

	// Classified operand: sign and magnitude, plus a cleaned mode.
	typedef struct packed {
		logic [2:0]  mode;
		logic        a_neg;
		logic [32:0] a_nm;
		logic [32:0] a_dm;
		logic        b_neg;
		logic [32:0] b_nm;
		logic [32:0] b_dm;
		logic        err;
	} job_t;
endpackage

@@ src/rau_front.sv @@
// Front end: accepts items, classifies them and writes them to the job queue.
module rau_front #(
	parameter int WORD_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             stall,
	input  rau_pkg::in_item_t in_item,
	output logic             job_valid,
	input  logic             job_stall,
	output rau_pkg::job_t    job
);
	localparam int DEPTH = 2;
	rau_pkg::job_t fifo_q [DEPTH];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	rau_pkg::job_t nj;
	logic push, pop;

	function automatic logic [32:0] mag(input logic [31:0] v, output logic neg);
		logic [32:0] s;
		begin
			s   = 33'(signed'(v[WORD_BITS-1:0]));
			neg = s[32];
			mag = neg ? (33'd0 - s) : s;
		end
	endfunction

	always_comb begin
		logic [2:0] m;
		logic dn, an;
		m = in_item.mode;
		if (m > rau_pkg::MODE_EQ) m = rau_pkg::MODE_NORM;
		nj = '0;
		nj.mode  = m;
		nj.a_nm  = mag(in_item.a_num, an);
		nj.a_dm  = mag(in_item.a_den, dn);
		nj.a_neg = an ^ dn;
		nj.b_nm  = mag(in_item.b_num, an);
		nj.b_dm  = mag(in_item.b_den, dn);
		nj.b_neg = an ^ dn;
		nj.err   = (nj.a_dm == '0) || (m != rau_pkg::MODE_NORM && nj.b_dm == '0) ||
			(m == rau_pkg::MODE_DIV && nj.b_nm == '0);
	end

	assign stall     = (cnt_q == 2'(DEPTH));
	assign push      = valid && !stall;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_valid && !job_stall;
	assign job       = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ src/rau_divu.sv @@
// Iterative 64-bit unsigned divider, one quotient bit per cycle.
module rau_divu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic [63:0] quo,
	output logic [63:0] rem
);
	logic [63:0] q_q, r_q, d_q;
	logic [6:0]  n_q;
	logic [64:0] sh;
	assign busy = (n_q != 7'd0);
	assign quo  = q_q;
	assign rem  = r_q;
	assign sh   = {r_q, q_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (start) begin
			n_q <= 7'd64;
		end else if (busy) begin
			n_q <= n_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy) begin
			if (sh >= {1'b0, d_q}) begin
				r_q <= 64'(sh - {1'b0, d_q});
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= sh[63:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule

@@ src/rau_back.sv @@
// Back end: sequencer that reduces operands and computes each result.
module rau_back #(
	parameter int WORD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_stall,
	input  rau_pkg::job_t     job,
	output logic              valid,
	input  logic              stall,
	output rau_pkg::out_item_t out_item
);
	`include "rational_arith_unit_macros.svh"

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_GCD  = 4'd1;
	localparam logic [3:0] S_GWT  = 4'd2;
	localparam logic [3:0] S_QN   = 4'd3;
	localparam logic [3:0] S_QNW  = 4'd4;
	localparam logic [3:0] S_QDW  = 4'd5;
	localparam logic [3:0] S_NEXT = 4'd6;
	localparam logic [3:0] S_OUT  = 4'd7;
	// Steps of the operation program.
	localparam logic [3:0] P_RA   = 4'd0;
	localparam logic [3:0] P_RB   = 4'd1;
	localparam logic [3:0] P_OP   = 4'd2;
	localparam logic [3:0] P_LG   = 4'd3;
	localparam logic [3:0] P_LX   = 4'd4;
	localparam logic [3:0] P_LY   = 4'd5;
	localparam logic [3:0] P_SUM  = 4'd6;
	localparam logic [3:0] P_MP   = 4'd7;
	localparam logic [3:0] P_MD   = 4'd8;
	localparam logic [3:0] P_FIN  = 4'd9;

	logic [3:0]  st_q, pc_q;
	logic [2:0]  mode_q;
	logic        an_q, bn_q, rn_q;
	logic [63:0] an_m_q, ad_q, bn_m_q, bd_q, rnum_q, rden_q;
	logic [63:0] x_q, y_q, g_q, l_q, m1_q;
	logic        ovalid_q;
	rau_pkg::out_item_t out_q, res_q;

	logic        dv_start, dv_busy;
	logic [63:0] dv_a, dv_b, dv_q, dv_r;

	// Shared 32x32 multiplier operands, registered product.
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;

	logic [63:0] sum_mag;
	logic        sum_neg;
	logic        out_ok;

	rau_divu u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .busy(dv_busy), .quo(dv_q), .rem(dv_r)
	);

	localparam logic [63:0] HALF = 64'd1 << (WORD_BITS - 1);

	assign job_stall = (st_q != S_IDLE);
	assign valid     = ovalid_q;
	assign out_item  = out_q;
	assign out_ok    = (out_item.status == rau_pkg::ST_OK);

	always_comb begin
		dv_start = 1'b0;
		dv_a = x_q;
		dv_b = y_q;
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_GCD: dv_start = (y_q != '0);
			S_QN: begin
				dv_start = 1'b1;
				dv_a = rnum_q;
				dv_b = g_q;
			end
			S_QNW: begin
				dv_start = !dv_busy;
				dv_a = rden_q;
				dv_b = g_q;
			end
			default: ;
		endcase
		// The product of each step is read in the step that follows it.
		case (pc_q)
			P_OP: begin
				mul_a = an_m_q[31:0];
				mul_b = (mode_q == rau_pkg::MODE_DIV) ? bd_q[31:0] : bn_m_q[31:0];
			end
			P_MP: begin
				mul_a = ad_q[31:0];
				mul_b = (mode_q == rau_pkg::MODE_DIV) ? bn_m_q[31:0] : bd_q[31:0];
			end
			P_LG: begin mul_a = rnum_q[31:0]; mul_b = bd_q[31:0]; end
			P_LX: begin mul_a = an_m_q[31:0]; mul_b = rden_q[31:0]; end
			P_LY: begin mul_a = bn_m_q[31:0]; mul_b = rnum_q[31:0]; end
			default: ;
		endcase
		if (an_q == bn_q) begin
			sum_mag = m1_q + prod_q; sum_neg = an_q;
		end else if (m1_q >= prod_q) begin
			sum_mag = m1_q - prod_q; sum_neg = an_q;
		end else begin
			sum_mag = prod_q - m1_q; sum_neg = bn_q;
		end
	end

	always_ff @(posedge clk) prod_q <= 64'(mul_a) * 64'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			pc_q     <= P_RA;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !stall) ovalid_q <= 1'b0;
			case (st_q)
				S_IDLE: if (job_valid) begin
					mode_q <= job.mode;
					an_q <= job.a_neg; bn_q <= job.b_neg;
					an_m_q <= 64'(job.a_nm); ad_q <= 64'(job.a_dm);
					bn_m_q <= 64'(job.b_nm); bd_q <= 64'(job.b_dm);
					if (job.err) begin
						res_q <= '{res_num: '0, res_den: '0, equal: 1'b0,
							status: rau_pkg::ST_ZERO};
						st_q <= S_OUT;
					end else begin
						rn_q <= job.a_neg;
						rnum_q <= 64'(job.a_nm); rden_q <= 64'(job.a_dm);
						x_q <= 64'(job.a_nm); y_q <= 64'(job.a_dm);
						pc_q <= P_RA;
						st_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (y_q == '0) begin
						g_q <= (x_q == '0) ? 64'd1 : x_q;
						st_q <= S_QN;
					end else begin
						st_q <= S_GWT;
					end
				end
				S_GWT: if (!dv_busy && !dv_start) begin
					x_q <= y_q; y_q <= dv_r; st_q <= S_GCD;
				end
				S_QN: st_q <= S_QNW;
				S_QNW: if (!dv_busy) begin
					rnum_q <= dv_q; st_q <= S_QDW;
				end
				S_QDW: if (!dv_busy && !dv_start) begin
					rden_q <= dv_q; st_q <= S_NEXT;
					if (rnum_q == '0) begin rden_q <= 64'd1; rn_q <= 1'b0; end
				end
				S_NEXT: begin
					case (pc_q)
						P_RA: begin
							an_m_q <= rnum_q; ad_q <= rden_q; an_q <= rn_q;
							if (mode_q == rau_pkg::MODE_NORM) begin
								pc_q <= P_FIN;
							end else begin
								rn_q <= bn_q; rnum_q <= bn_m_q; rden_q <= bd_q;
								x_q <= bn_m_q; y_q <= bd_q;
								pc_q <= P_RB; st_q <= S_GCD;
							end
						end
						P_RB: begin
							bn_m_q <= rnum_q; bd_q <= rden_q;
							bn_q <= (mode_q == rau_pkg::MODE_SUB && rnum_q != '0)
								? !rn_q : rn_q;
							pc_q <= P_OP;
						end
						P_OP: begin
							case (mode_q)
								rau_pkg::MODE_EQ: begin
									res_q <= '{res_num: '0, res_den: '0,
										equal: (an_q == bn_q && an_m_q == bn_m_q &&
											ad_q == bd_q), status: rau_pkg::ST_OK};
									st_q <= S_OUT;
								end
								rau_pkg::MODE_MUL, rau_pkg::MODE_DIV: begin
									rn_q <= an_q ^ bn_q; pc_q <= P_MP;
								end
								default: begin
									// Reducing ad/bd by their gcd gives the two
									// cofactors of the common denominator.
									x_q <= ad_q; y_q <= bd_q;
									rnum_q <= ad_q; rden_q <= bd_q;
									pc_q <= P_LG; st_q <= S_GCD;
								end
							endcase
						end
						P_MP: begin
							rnum_q <= prod_q; pc_q <= P_MD;
						end
						P_MD: begin
							rden_q <= prod_q;
							x_q <= rnum_q; y_q <= prod_q;
							pc_q <= P_FIN; st_q <= S_GCD;
						end
						P_LG: begin
							pc_q <= P_LX;
						end
						P_LX: begin
							l_q <= prod_q; pc_q <= P_LY;
						end
						P_LY: begin
							m1_q <= prod_q; pc_q <= P_SUM;
						end
						P_SUM: begin
							rnum_q <= sum_mag; rn_q <= sum_neg; rden_q <= l_q;
							x_q <= sum_mag; y_q <= l_q;
							pc_q <= P_FIN; st_q <= S_GCD;
						end
						default: begin
							// P_FIN
							if (rden_q > HALF - 64'd1 ||
								(rn_q ? rnum_q > HALF : rnum_q > HALF - 64'd1)) begin
								res_q <= '{res_num: '0, res_den: '0, equal: 1'b0,
									status: rau_pkg::ST_OVF};
							end else begin
								res_q <= '{res_num: 32'(rn_q ? (64'd0 - rnum_q) : rnum_q),
									res_den: 31'(rden_q), equal: 1'b0,
									status: rau_pkg::ST_OK};
							end
							st_q <= S_OUT;
						end
					endcase
				end
				S_OUT: if (!ovalid_q) begin
					out_q <= res_q;
					ovalid_q <= 1'b1; st_q <= S_IDLE; pc_q <= P_RA;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`RAU_ASSERT_NXT(a_out_stable, valid && stall, valid && $stable(out_item))
	`RAU_ASSERT_IMP(a_err_clear, valid && !out_ok, out_item.res_num == '0 && out_item.res_den == '0)
	`RAU_ASSERT_IMP(a_eq_form, valid && out_item.equal, out_ok && out_item.res_den == '0)
	`RAU_ASSERT_IMP(a_ok_den, valid && out_ok && out_item.res_num != '0, out_item.res_den != '0)
endmodule

@@ src/rational_arith_unit.sv @@
// Rational arithmetic unit: reduce, add, subtract, multiply, divide, compare fractions.
// An item flagged in error (zero denominator, or zero divisor in a divide) goes straight to
// the output; otherwise each reduction runs Euclid steps on the bit-serial 64-bit divider,
// with one to four reductions per item.
// Throughput: one item at a time in the back end; a two-entry queue lets input continue.
// Reset: arst_n clears the queue, the sequencer and the output valid at once.
module rational_arith_unit #(
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rau_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output rau_pkg::out_item_t out_item
);
	logic          jv, js;
	rau_pkg::job_t job;

	rau_front #(.WORD_BITS(WORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.in_item(in_item), .job_valid(jv), .job_stall(js), .job(job)
	);

	rau_back #(.WORD_BITS(WORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(jv), .job_stall(js), .job(job),
		.valid(out_valid), .stall(out_stall), .out_item(out_item)
	);
endmodule
